FILE: rtl/core/fege_pkg.sv
// ----------------------------------------------------------------------------
// Fire effect grid engine package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package fege_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_JITTER = 2'd1,
        KIND_BLUR   = 2'd2,
        KIND_SHADE  = 2'd3
    } fege_kind_t;

    typedef enum logic [1:0] {
        RSEL_CELL  = 2'd0,
        RSEL_BELOW = 2'd1,
        RSEL_LEFT  = 2'd2,
        RSEL_RIGHT = 2'd3
    } fege_rsel_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_CELL   = 3'd2,
        ST_BELOW  = 3'd3,
        ST_LEFT   = 3'd4,
        ST_RIGHT  = 3'd5,
        ST_SUM    = 3'd6,
        ST_FINISH = 3'd7
    } fege_state_t;

    typedef struct packed {
        logic       capture;
        logic       clr_wr;
        logic       rd_en;
        fege_rsel_t rd_sel;
        logic       cell_ld;
        logic       acc_add;
        logic       finish;
    } fege_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic blur_go;
        logic has_left;
        logic has_right;
    } fege_stat_t;

    localparam logic       CFG_COOL_OFFSET   = 1'b0;
    localparam logic       CFG_JITTER_CENTRE = 1'b1;
    localparam logic [7:0] COOL_RESET        = 8'd3;
    localparam logic [7:0] CENTRE_RESET      = 8'd40;
    localparam logic [7:0] PIXEL_MAX         = 8'hFF;
    localparam logic [15:0] BLUR_RECIP       = 16'd52429;
    localparam int         BLUR_SHIFT        = 18;
    localparam int         SHADE_SHIFT       = 5;

endpackage

FILE: rtl/core/fege_ctrl.sv
// ----------------------------------------------------------------------------
// Fire effect grid engine controller
// Sequences the clearing pass and the memory reads of each cell operation.
// ----------------------------------------------------------------------------
module fege_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fege_pkg::fege_stat_t stat,
    output fege_pkg::fege_cmd_t  cmd,
    output logic                busy
);
    import fege_pkg::*;

    fege_state_t state_reg;
    fege_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_sel  = RSEL_CELL;
        busy        = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL:
            begin
                cmd.rd_en  = 1'b1;
                state_next = stat.blur_go ? ST_BELOW : ST_FINISH;
            end
            ST_BELOW:
            begin
                cmd.cell_ld = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RSEL_BELOW;
                state_next  = ST_LEFT;
            end
            ST_LEFT:
            begin
                cmd.acc_add = 1'b1;
                cmd.rd_en   = stat.has_left;
                cmd.rd_sel  = RSEL_LEFT;
                state_next  = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                cmd.acc_add = stat.has_left;
                cmd.rd_en   = stat.has_right;
                cmd.rd_sel  = RSEL_RIGHT;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.acc_add = stat.has_right;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/fege_dpath.sv
// ----------------------------------------------------------------------------
// Fire effect grid engine datapath
// Grid memory, operand capture, blur accumulator, shade and clamp arithmetic.
// ----------------------------------------------------------------------------
module fege_dpath #(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fege_pkg::fege_cmd_t  cmd,
    output fege_pkg::fege_stat_t stat,
    input  logic [1:0]           kind,
    input  logic [4:0]           column,
    input  logic [5:0]           row,
    input  logic [7:0]           draw,
    input  logic [7:0]           noise_a,
    input  logic [7:0]           noise_b,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    output logic [7:0]           pixel_value,
    output logic                 done
);
    import fege_pkg::*;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = ($clog2(GRID_HEIGHT) > 6) ? $clog2(GRID_HEIGHT) : 6;
    localparam logic [ROW_W-1:0]  BOTTOM_ROW = ROW_W'(GRID_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] OFS_BELOW  = ADDR_W'(GRID_WIDTH);
    localparam logic [ADDR_W-1:0] OFS_LEFT   = ADDR_W'(GRID_WIDTH - 1);
    localparam logic [ADDR_W-1:0] OFS_RIGHT  = ADDR_W'(GRID_WIDTH + 1);

    logic [7:0]        grid_mem [CELL_COUNT];

    fege_kind_t        kind_reg;
    logic [4:0]        col_reg;
    logic [5:0]        row_reg;
    logic [7:0]        draw_reg;
    logic [7:0]        na_reg;
    logic [7:0]        nb_reg;
    logic [7:0]        cool_reg;
    logic [7:0]        centre_reg;
    logic [7:0]        shade_p_reg;
    logic [10:0]       acc_reg;
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [7:0]        pixel_value_reg;
    logic              done_reg;

    logic [ROW_W-1:0]  eff_row;
    logic              in_range;
    logic              is_bottom;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    logic [15:0]        noise_prod;
    logic [26:0]        blur_prod;
    logic [8:0]         blur_q;
    logic signed [9:0]  jit_sum;
    logic signed [10:0] blur_sum;
    logic [15:0]        shade_prod;
    logic [11:0]        shade_sum;
    logic [7:0]         fin_val;
    logic               fin_wr;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= fege_kind_t'(kind);
            col_reg  <= column;
            row_reg  <= row;
            draw_reg <= draw;
            na_reg   <= noise_a;
            nb_reg   <= noise_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cool_reg   <= COOL_RESET;
            centre_reg <= CENTRE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COOL_OFFSET:   cool_reg   <= cfg_data;
                CFG_JITTER_CENTRE: centre_reg <= cfg_data;
                default:           cool_reg   <= cool_reg;
            endcase
        end
    end

    assign eff_row   = (kind_reg == KIND_JITTER) ? BOTTOM_ROW : ROW_W'(row_reg);
    assign in_range  = (32'(col_reg) < GRID_WIDTH) && (32'(eff_row) < GRID_HEIGHT);
    assign is_bottom = (eff_row == BOTTOM_ROW);
    assign base_addr = ADDR_W'(32'(eff_row) * GRID_WIDTH + 32'(col_reg));

    assign stat.clr_last  = (clr_addr_reg == LAST_ADDR);
    assign stat.blur_go   = in_range && (kind_reg == KIND_BLUR) && !is_bottom;
    assign stat.has_left  = (col_reg != 5'd0);
    assign stat.has_right = (32'(col_reg) + 1 < GRID_WIDTH);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RSEL_CELL:  rd_addr = base_addr;
            RSEL_BELOW: rd_addr = base_addr + OFS_BELOW;
            RSEL_LEFT:  rd_addr = base_addr + OFS_LEFT;
            RSEL_RIGHT: rd_addr = base_addr + OFS_RIGHT;
            default:    rd_addr = base_addr;
        endcase
    end

    assign mem_we    = cmd.clr_wr | (cmd.finish & fin_wr);
    assign mem_waddr = cmd.clr_wr ? clr_addr_reg : base_addr;
    assign mem_wdata = cmd.clr_wr ? 8'd0 : fin_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    assign noise_prod = 16'(na_reg) * 16'(nb_reg);

    always_ff @(posedge clk)
    begin
        shade_p_reg <= noise_prod[15:8];
        if (cmd.cell_ld)
        begin
            acc_reg <= {2'b00, rd_data_reg, 1'b0};
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + 11'(rd_data_reg);
        end
    end

    assign blur_prod  = 27'(acc_reg) * 27'(BLUR_RECIP);
    assign blur_q     = 9'(blur_prod >> BLUR_SHIFT);
    assign jit_sum    = $signed({2'b00, rd_data_reg}) + $signed({2'b00, draw_reg})
                        - $signed({2'b00, centre_reg});
    assign blur_sum   = $signed({2'b00, blur_q}) + $signed({3'b000, draw_reg})
                        - $signed({3'b000, cool_reg});
    assign shade_prod = 16'(rd_data_reg) * 16'(shade_p_reg);
    assign shade_sum  = 12'(shade_prod >> SHADE_SHIFT) + 12'(rd_data_reg >> 1);

    always_comb
    begin
        fin_val = 8'd0;
        fin_wr  = 1'b0;
        if (in_range)
        begin
            unique case (kind_reg)
                KIND_WRITE:
                begin
                    fin_val = draw_reg;
                    fin_wr  = 1'b1;
                end
                KIND_JITTER:
                begin
                    fin_wr = 1'b1;
                    if (jit_sum < 10'sd0)
                    begin
                        fin_val = 8'd0;
                    end
                    else if (jit_sum > 10'sd255)
                    begin
                        fin_val = PIXEL_MAX;
                    end
                    else
                    begin
                        fin_val = jit_sum[7:0];
                    end
                end
                KIND_BLUR:
                begin
                    if (is_bottom)
                    begin
                        fin_val = rd_data_reg;
                    end
                    else
                    begin
                        fin_wr = 1'b1;
                        if (blur_sum < 11'sd0)
                        begin
                            fin_val = 8'd0;
                        end
                        else if (blur_sum > 11'sd255)
                        begin
                            fin_val = PIXEL_MAX;
                        end
                        else
                        begin
                            fin_val = blur_sum[7:0];
                        end
                    end
                end
                KIND_SHADE:
                begin
                    fin_val = (shade_sum > 12'(PIXEL_MAX)) ? PIXEL_MAX : shade_sum[7:0];
                end
                default:
                begin
                    fin_val = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            pixel_value_reg <= fin_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign pixel_value = pixel_value_reg;
    assign done        = done_reg;

endmodule

FILE: rtl/core/fire_effect_grid_engine.sv
// ----------------------------------------------------------------------------
// Fire effect grid engine
// Keeps a grid of 8-bit fire intensities and runs one cell operation per
// transaction: write, jitter, blur or shade.
//
// Drive kind, column, row, draw, noise_a and noise_b with start high; the
// transaction is taken at an edge where busy is low. One result per
// transaction appears on pixel_value with done high for exactly one cycle.
// Write, jitter, shade, bottom-row blur and out-of-grid transactions go from
// ST_CELL straight to ST_FINISH. Any other blur also passes through ST_BELOW,
// ST_LEFT, ST_RIGHT and ST_SUM: its grid reads, up to four, share the single
// read port of the grid memory, one read per cycle. The done cycle is also
// the first cycle with busy low, so a new transaction may be started while
// the result is on the ports. The receiver cannot hold results off; a result
// not taken in its cycle is gone. After reset the grid is cleared by a pass
// that writes zero to each of the GRID_WIDTH * GRID_HEIGHT cells, during
// which busy stays high; configuration writes on cfg_we, cfg_index and
// cfg_data are taken at any time and reset to their defaults.
// ----------------------------------------------------------------------------
module fire_effect_grid_engine #(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [4:0] column,
    input  logic [5:0] row,
    input  logic [7:0] draw,
    input  logic [7:0] noise_a,
    input  logic [7:0] noise_b,
    output logic [7:0] pixel_value,
    output logic       done,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import fege_pkg::*;

    fege_cmd_t  cmd;
    fege_stat_t stat;

    fege_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    fege_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .column      (column),
        .row         (row),
        .draw        (draw),
        .noise_a     (noise_a),
        .noise_b     (noise_b),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_value (pixel_value),
        .done        (done)
    );

    a_done_follows_finish: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.finish)
    ) else $error("result strobe without a finishing step");

    a_accept_goes_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done
    ) else $error("accepted transaction did not make the engine busy");

    a_clear_excludes_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> busy && !cmd.capture && !cmd.finish && !done
    ) else $error("clearing pass overlaps a transaction");

endmodule

FILE: dv/tb_fire_effect_grid_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire effect grid engine testbench
// Runs a table of directed cell operations and then random phases of
// write, jitter, blur and shade transactions under several cooling and
// jitter settings. Senders work in random bursts and gaps. Every result is
// checked against a known value or a grid model kept in step with each op.
// ----------------------------------------------------------------------------
module tb_fire_effect_grid_engine;
    import fege_pkg::*;

    localparam int GRID_W     = 32;
    localparam int GRID_H     = 64;
    localparam int SEED_ROWS  = 22;
    localparam int PHASES     = 6;
    localparam int PHASE_OPS  = 225;
    localparam int QUIET_MAX  = 10000;

    typedef struct packed {
        fege_kind_t op;
        logic [4:0] col;
        logic [5:0] row;
        logic [7:0] draw;
        logic [7:0] na;
        logic [7:0] nb;
        logic       known;
        logic [7:0] pix;
    } flame_op_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] kind = KIND_WRITE;
    logic [4:0] column = '0;
    logic [5:0] row = '0;
    logic [7:0] draw = '0;
    logic [7:0] noise_a = '0;
    logic [7:0] noise_b = '0;
    logic [7:0] pixel_value;
    logic       done;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_COOL_OFFSET;
    logic [7:0] cfg_data = '0;

    logic [7:0] heat_map [0:GRID_W*GRID_H-1];
    logic [7:0] cool_set;
    logic [7:0] centre_set;
    logic [7:0] expected_pixels [$];
    logic [7:0] pixel_want;
    int         fail_count = 0;
    int         quiet_cycles = 0;

    fire_effect_grid_engine #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .column      (column),
        .row         (row),
        .draw        (draw),
        .noise_a     (noise_a),
        .noise_b     (noise_b),
        .pixel_value (pixel_value),
        .done        (done),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic flame_op_t cell_op(input fege_kind_t op, input int c, input int r,
                                          input int d, input int a, input int b,
                                          input bit known, input int pix);
        flame_op_t t;
        t.op    = op;
        t.col   = c[4:0];
        t.row   = r[5:0];
        t.draw  = d[7:0];
        t.na    = a[7:0];
        t.nb    = b[7:0];
        t.known = known;
        t.pix   = pix[7:0];
        return t;
    endfunction

    function automatic int pixel_clamp(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    function automatic logic [7:0] next_pixel(input flame_op_t t);
        int r, c, d, heat, acc, base;
        logic [7:0] pix;
        r = (t.op == KIND_JITTER) ? GRID_H - 1 : int'(t.row);
        c = int'(t.col);
        d = int'(t.draw);
        pix = '0;
        if (c < GRID_W && r < GRID_H)
        begin
            base = r * GRID_W + c;
            heat = int'(heat_map[base]);
            case (t.op)
                KIND_WRITE:
                begin
                    pix = t.draw;
                    heat_map[base] = pix;
                end
                KIND_JITTER:
                begin
                    acc = pixel_clamp(heat + d - int'(centre_set));
                    pix = acc[7:0];
                    heat_map[base] = pix;
                end
                KIND_BLUR:
                begin
                    if (r == GRID_H - 1)
                    begin
                        pix = heat[7:0];
                    end
                    else
                    begin
                        acc = 2 * heat + int'(heat_map[base + GRID_W]);
                        if (c > 0)
                            acc += int'(heat_map[base + GRID_W - 1]);
                        if (c + 1 < GRID_W)
                            acc += int'(heat_map[base + GRID_W + 1]);
                        acc = pixel_clamp(acc / 5 + d - int'(cool_set));
                        pix = acc[7:0];
                        heat_map[base] = pix;
                    end
                end
                default:
                begin
                    acc = (int'(t.na) * int'(t.nb)) >> 8;
                    acc = ((heat * acc) >> 5) + (heat >> 1);
                    if (acc > 255)
                        acc = 255;
                    pix = acc[7:0];
                end
            endcase
        end
        return pix;
    endfunction

    function automatic flame_op_t random_op();
        int pick, c, r;
        fege_kind_t op;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            op = KIND_WRITE;
        else if (pick < 45)
            op = KIND_JITTER;
        else if (pick < 85)
            op = KIND_BLUR;
        else
            op = KIND_SHADE;
        c = $urandom_range(0, GRID_W - 1);
        if ($urandom_range(0, 9) < 7)
            r = $urandom_range(GRID_H - 8, GRID_H - 1);
        else
            r = $urandom_range(0, GRID_H - 1);
        return cell_op(op, c, r, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), 1'b0, 0);
    endfunction

    task automatic send_op(input flame_op_t t);
        logic [7:0] want;
        start   <= 1'b1;
        kind    <= t.op;
        column  <= t.col;
        row     <= t.row;
        draw    <= t.draw;
        noise_a <= t.na;
        noise_b <= t.nb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = next_pixel(t);
        if (t.known)
            want = t.pix;
        expected_pixels.push_back(want);
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic [7:0] cool, input logic [7:0] centre);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COOL_OFFSET;
        cfg_data  <= cool;
        @(posedge clk);
        cfg_index <= CFG_JITTER_CENTRE;
        cfg_data  <= centre;
        @(posedge clk);
        cfg_we <= 1'b0;
        cool_set   = cool;
        centre_set = centre;
    endtask

    task automatic run_phase(input int count);
        int sent, burst, gap, j;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (j = 0; j < burst && sent < count; j++)
            begin
                send_op(random_op());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0 && sent < count)
            begin
                start <= 1'b0;
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: pixel_value expected none actual %0d", $time, pixel_value);
                fail_count++;
            end
            else
            begin
                pixel_want = expected_pixels.pop_front();
                if (pixel_value !== pixel_want)
                begin
                    $display("%0t: pixel_value expected %0d actual %0d",
                             $time, pixel_want, pixel_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("tb_fire_effect_grid_engine: FAIL");
            $finish;
        end
    end

    initial
    begin
        flame_op_t seed_table [SEED_ROWS];
        int        i, ph;
        logic [7:0] cool_plan [PHASES];
        logic [7:0] centre_plan [PHASES];

        for (i = 0; i < GRID_W * GRID_H; i++)
            heat_map[i] = '0;
        cool_set   = COOL_RESET;
        centre_set = CENTRE_RESET;

        seed_table[0]  = cell_op(KIND_SHADE,   0,  0,   0, 255, 255, 1'b1,   0);
        seed_table[1]  = cell_op(KIND_BLUR,    5, 10,   0,   0,   0, 1'b1,   0);
        seed_table[2]  = cell_op(KIND_WRITE,  31, 63, 255,   0,   0, 1'b1, 255);
        seed_table[3]  = cell_op(KIND_WRITE,   0,  0,   0, 255, 255, 1'b1,   0);
        seed_table[4]  = cell_op(KIND_JITTER, 31,  0, 255,   0,   0, 1'b1, 255);
        seed_table[5]  = cell_op(KIND_JITTER,  0, 63,   0,   0,   0, 1'b1,   0);
        seed_table[6]  = cell_op(KIND_JITTER,  0, 21, 255,   0,   0, 1'b1, 215);
        seed_table[7]  = cell_op(KIND_BLUR,   31, 63,   0,   0,   0, 1'b1, 255);
        seed_table[8]  = cell_op(KIND_SHADE,  31, 63,   0, 255, 255, 1'b1, 255);
        seed_table[9]  = cell_op(KIND_SHADE,  31, 63,   0,   0,   0, 1'b1, 127);
        seed_table[10] = cell_op(KIND_WRITE,   1, 63, 100,   0,   0, 1'b1, 100);
        seed_table[11] = cell_op(KIND_BLUR,    0, 62,   0,   0,   0, 1'b0,   0);
        seed_table[12] = cell_op(KIND_BLUR,   31, 62, 255,   0,   0, 1'b0,   0);
        seed_table[13] = cell_op(KIND_WRITE,  15, 20, 200,   0,   0, 1'b1, 200);
        seed_table[14] = cell_op(KIND_BLUR,   15, 20,   0,   0,   0, 1'b0,   0);
        seed_table[15] = cell_op(KIND_SHADE,  15, 20,   0, 128, 255, 1'b0,   0);
        seed_table[16] = cell_op(KIND_WRITE,  21, 42, 170,  85, 170, 1'b1, 170);
        seed_table[17] = cell_op(KIND_WRITE,  10, 21,  85, 170,  85, 1'b1,  85);
        seed_table[18] = cell_op(KIND_BLUR,   21, 41, 255,   0,   0, 1'b0,   0);
        seed_table[19] = cell_op(KIND_JITTER, 10,  0,  40,   0,   0, 1'b0,   0);
        seed_table[20] = cell_op(KIND_SHADE,   0, 63,   0, 255,   0, 1'b0,   0);
        seed_table[21] = cell_op(KIND_BLUR,   16,  0, 128,   0,   0, 1'b0,   0);

        cool_plan   = '{8'd0,   8'd255, 8'd7,   8'd128, 8'd3,  8'd0};
        centre_plan = '{8'd255, 8'd0,   8'd128, 8'd7,   8'd40, 8'd0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_settings(COOL_RESET, CENTRE_RESET);

        for (i = 0; i < SEED_ROWS; i++)
            send_op(seed_table[i]);
        start <= 1'b0;
        wait_drained();

        for (ph = 0; ph < PHASES; ph++)
        begin
            repeat (4) @(posedge clk);
            if (ph == PHASES - 1)
                write_settings($urandom_range(0, 255), $urandom_range(0, 255));
            else
                write_settings(cool_plan[ph], centre_plan[ph]);
            run_phase(PHASE_OPS);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_fire_effect_grid_engine: PASS");
        else
            $display("tb_fire_effect_grid_engine: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fege_pkg.sv
rtl/core/fege_ctrl.sv
rtl/core/fege_dpath.sv
rtl/core/fire_effect_grid_engine.sv
dv/tb_fire_effect_grid_engine.sv
